// ===== rtl/pss_pkg.sv =====
package pss_pkg;

	localparam int COORD_BITS = 24;
	localparam int THR_W      = 24;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int MUL_W      = (DIFF_W > THR_W) ? DIFF_W : THR_W;
	localparam int SQ_W       = 2 * MUL_W;
	localparam int DOT_W      = SQ_W + 1;
	localparam int ACC_W      = 4 * MUL_W + 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = THR_W;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_Z     = 2'd1;

	localparam int NSTEPS = 23;
	localparam int STEP_W = $clog2(NSTEPS);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_coord;
		logic signed [COORD_BITS-1:0] y_coord;
		logic signed [COORD_BITS-1:0] z_coord;
		logic                         last_point;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] kept_x;
		logic signed [COORD_BITS-1:0] kept_y;
		logic signed [COORD_BITS-1:0] kept_z;
		logic                         line_end;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		POS_START,
		POS_SECOND,
		POS_MIDDLE
	} pos_t;

	typedef enum logic [3:0] {
		SRC_NONE,
		SRC_D,
		SRC_S,
		SRC_THR,
		SRC_DIFFD_LO,
		SRC_DIFFD_HI,
		SRC_SUBD_LO,
		SRC_SUBD_HI,
		SRC_SP_LO,
		SRC_SP_HI,
		SRC_THR2_LO,
		SRC_THR2_HI
	} src_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_DIFFD,
		DST_SUBD,
		DST_DOT,
		DST_THR2,
		DST_SP,
		DST_BIG
	} dst_t;

	typedef struct packed {
		src_t       a_src;
		src_t       b_src;
		logic [1:0] comp;
		dst_t       dst;
		logic       neg;
		logic [1:0] shift;
	} op_t;

	function automatic op_t mk_op(input src_t a, input src_t b, input logic [1:0] comp,
			input dst_t dst, input logic neg, input logic [1:0] shift);
		op_t op;
		op.a_src = a;
		op.b_src = b;
		op.comp  = comp;
		op.dst   = dst;
		op.neg   = neg;
		op.shift = shift;
		return op;
	endfunction

	// Micro-op sequence of one strip test. Small products first, then the
	// half-word partial products of lhs - rhs into the big accumulator.
	function automatic op_t op_at(input logic [STEP_W-1:0] step);
		op_t op;
		op = mk_op(SRC_NONE, SRC_NONE, 2'd0, DST_NONE, 1'b0, 2'd0);
		case (step)
			STEP_W'(0):  op = mk_op(SRC_D, SRC_D, 2'd0, DST_DIFFD, 1'b0, 2'd0);
			STEP_W'(1):  op = mk_op(SRC_D, SRC_S, 2'd0, DST_DOT, 1'b0, 2'd0);
			STEP_W'(2):  op = mk_op(SRC_S, SRC_S, 2'd0, DST_SUBD, 1'b0, 2'd0);
			STEP_W'(3):  op = mk_op(SRC_D, SRC_D, 2'd1, DST_DIFFD, 1'b0, 2'd0);
			STEP_W'(4):  op = mk_op(SRC_D, SRC_S, 2'd1, DST_DOT, 1'b0, 2'd0);
			STEP_W'(5):  op = mk_op(SRC_S, SRC_S, 2'd1, DST_SUBD, 1'b0, 2'd0);
			STEP_W'(6):  op = mk_op(SRC_D, SRC_D, 2'd2, DST_DIFFD, 1'b0, 2'd0);
			STEP_W'(7):  op = mk_op(SRC_D, SRC_S, 2'd2, DST_DOT, 1'b0, 2'd0);
			STEP_W'(8):  op = mk_op(SRC_S, SRC_S, 2'd2, DST_SUBD, 1'b0, 2'd0);
			STEP_W'(9):  op = mk_op(SRC_THR, SRC_THR, 2'd0, DST_THR2, 1'b0, 2'd0);
			STEP_W'(10): op = mk_op(SRC_NONE, SRC_NONE, 2'd0, DST_SP, 1'b0, 2'd0);
			STEP_W'(11): op = mk_op(SRC_DIFFD_LO, SRC_SUBD_LO, 2'd0, DST_BIG, 1'b0, 2'd0);
			STEP_W'(12): op = mk_op(SRC_DIFFD_LO, SRC_SUBD_HI, 2'd0, DST_BIG, 1'b0, 2'd1);
			STEP_W'(13): op = mk_op(SRC_DIFFD_HI, SRC_SUBD_LO, 2'd0, DST_BIG, 1'b0, 2'd1);
			STEP_W'(14): op = mk_op(SRC_DIFFD_HI, SRC_SUBD_HI, 2'd0, DST_BIG, 1'b0, 2'd2);
			STEP_W'(15): op = mk_op(SRC_SP_LO, SRC_SP_LO, 2'd0, DST_BIG, 1'b1, 2'd0);
			STEP_W'(16): op = mk_op(SRC_SP_LO, SRC_SP_HI, 2'd0, DST_BIG, 1'b1, 2'd1);
			STEP_W'(17): op = mk_op(SRC_SP_HI, SRC_SP_LO, 2'd0, DST_BIG, 1'b1, 2'd1);
			STEP_W'(18): op = mk_op(SRC_SP_HI, SRC_SP_HI, 2'd0, DST_BIG, 1'b1, 2'd2);
			STEP_W'(19): op = mk_op(SRC_THR2_LO, SRC_SUBD_LO, 2'd0, DST_BIG, 1'b1, 2'd0);
			STEP_W'(20): op = mk_op(SRC_THR2_LO, SRC_SUBD_HI, 2'd0, DST_BIG, 1'b1, 2'd1);
			STEP_W'(21): op = mk_op(SRC_THR2_HI, SRC_SUBD_LO, 2'd0, DST_BIG, 1'b1, 2'd1);
			STEP_W'(22): op = mk_op(SRC_THR2_HI, SRC_SUBD_HI, 2'd0, DST_BIG, 1'b1, 2'd2);
			default:     op = mk_op(SRC_NONE, SRC_NONE, 2'd0, DST_NONE, 1'b0, 2'd0);
		endcase
		return op;
	endfunction

endpackage

// ===== rtl/polyline_strip_simplifier.sv =====
// Streaming polyline simplifier: vertices of one polyline come in on the
// vertex channel, last one marked, and the kept ones leave on the kept channel
// in order. The first and last vertex of a line always pass; the second only
// sets the reference segment; a later vertex passes when its squared distance
// to the segment's line exceeds distance_threshold squared, tested exactly as
// |A-p|^2*|D|^2 > ((A-p).D)^2 + thr^2*|D|^2, so a zero-length segment never
// passes. A first, second or last vertex goes from transfer straight to the
// emit state; any other vertex goes through transfer, 23 micro-op issues, the
// drain state and emit, as the micro-ops go one at a time through the single
// MUL_W x MUL_W multiplier and its shared accumulate adder.
// The emit cycle waits while the kept register is full and stalled, yet a new
// vertex transfers while a kept vertex waits. Configuration writes are taken
// only while no vertex is in work.
module polyline_strip_simplifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                vertex_valid,
	output logic                                vertex_stall,
	input  pss_pkg::in_item_t                   vertex,
	output logic                                kept_valid,
	input  logic                                kept_stall,
	output pss_pkg::out_item_t                  kept,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pss_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CB     = pss_pkg::COORD_BITS;
	localparam int DW     = pss_pkg::DIFF_W;
	localparam int MW     = pss_pkg::MUL_W;
	localparam int SW     = pss_pkg::SQ_W;
	localparam int OW     = pss_pkg::DOT_W;
	localparam int AW     = pss_pkg::ACC_W;
	localparam int STW    = pss_pkg::STEP_W;

	// configuration
	logic [pss_pkg::THR_W-1:0] thr_q;
	logic                      use_z_q;

	// line state
	logic signed [CB-1:0] anchor_q [3];
	logic signed [DW-1:0] dir_q    [3];
	logic signed [CB-1:0] prev_q   [3];
	pss_pkg::pos_t        pos_q;

	// held vertex and its offset to the anchor
	logic signed [CB-1:0] pc_q [3];
	logic                 last_q;
	logic signed [DW-1:0] d_q  [3];
	logic signed [CB-1:0] p_in [3];

	// sequencer
	pss_pkg::state_t state_q, state_d;
	logic [STW-1:0]  step_q;

	// accumulators
	logic [SW-1:0]        diffd_q, subd_q, sp_q, thr2_q;
	logic signed [OW-1:0] dot_q;
	logic signed [AW-1:0] big_q;

	// multiply stage
	logic [2*MW-1:0]      prod_s1;
	pss_pkg::dst_t        dst_s1;
	logic [1:0]           shift_s1;
	logic                 sub_s1;
	logic                 vld_s1;

	// output register
	pss_pkg::out_item_t   out_q;
	logic                 out_valid_q;

	// control
	logic accept, issue, is_mid, pass, emit, out_free, done, load_out;
	pss_pkg::op_t op;

	assign p_in[0] = vertex.x_coord;
	assign p_in[1] = vertex.y_coord;
	assign p_in[2] = vertex.z_coord;

	assign accept   = vertex_valid && !vertex_stall;
	assign is_mid   = (pos_q != pss_pkg::POS_START) && (pos_q != pss_pkg::POS_SECOND);
	// strip test outcome: lhs - rhs strictly positive
	assign pass     = !big_q[AW-1] && (|big_q);
	assign out_free = !out_valid_q || !kept_stall;

	// Emit rules: first vertex always, second only when it ends the line,
	// later ones when last or outside the strip.
	always_comb begin
		case (pos_q)
			pss_pkg::POS_START:  emit = 1'b1;
			pss_pkg::POS_SECOND: emit = last_q;
			default:             emit = last_q || pass;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pss_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (is_mid && !vertex.last_point) ? pss_pkg::ST_CALC
						: pss_pkg::ST_EMIT;
				end
			end
			pss_pkg::ST_CALC: begin
				if (step_q == STW'(pss_pkg::NSTEPS - 1)) state_d = pss_pkg::ST_DRAIN;
			end
			pss_pkg::ST_DRAIN: state_d = pss_pkg::ST_EMIT;
			pss_pkg::ST_EMIT: begin
				if (done) state_d = pss_pkg::ST_IDLE;
			end
			default: state_d = pss_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		vertex_stall = 1'b1;
		cfg_ready    = 1'b0;
		issue        = 1'b0;
		done         = 1'b0;
		unique case (state_q)
			pss_pkg::ST_IDLE: begin
				vertex_stall = 1'b0;
				cfg_ready    = 1'b1;
			end
			pss_pkg::ST_CALC:  issue = 1'b1;
			pss_pkg::ST_DRAIN: ;
			pss_pkg::ST_EMIT:  done = !emit || out_free;
			default: ;
		endcase
	end

	assign load_out = done && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pss_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) step_q <= '0;
			else if (issue) step_q <= step_q + STW'(1);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			use_z_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pss_pkg::CFG_THRESHOLD: thr_q   <= cfg_data;
				pss_pkg::CFG_USE_Z:     use_z_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Capture the vertex and its offset to the anchor on transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 3; k++) begin
				pc_q[k] <= p_in[k];
				d_q[k]  <= DW'(anchor_q[k]) - DW'(p_in[k]);
			end
			last_q <= vertex.last_point;
		end
	end

	// Line state advances when the vertex leaves the emit cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= pss_pkg::POS_START;
			for (int k = 0; k < 3; k++) begin
				anchor_q[k] <= '0;
				dir_q[k]    <= '0;
				prev_q[k]   <= '0;
			end
		end else if (done) begin
			case (pos_q)
				pss_pkg::POS_START: begin
					for (int k = 0; k < 3; k++) begin
						anchor_q[k] <= pc_q[k];
						prev_q[k]   <= pc_q[k];
					end
					pos_q <= last_q ? pss_pkg::POS_START : pss_pkg::POS_SECOND;
				end
				pss_pkg::POS_SECOND: begin
					for (int k = 0; k < 3; k++) begin
						dir_q[k]  <= DW'(pc_q[k]) - DW'(anchor_q[k]);
						prev_q[k] <= pc_q[k];
					end
					pos_q <= last_q ? pss_pkg::POS_START : pss_pkg::POS_MIDDLE;
				end
				default: begin
					// a kept middle vertex opens the segment (previous, itself)
					for (int k = 0; k < 3; k++) begin
						if (!last_q && pass) begin
							anchor_q[k] <= prev_q[k];
							dir_q[k]    <= DW'(pc_q[k]) - DW'(prev_q[k]);
						end
						prev_q[k] <= pc_q[k];
					end
					pos_q <= last_q ? pss_pkg::POS_START : pss_pkg::POS_MIDDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Shared multiplier: pick operands for the current micro-op.
	// ---------------------------------------------------------------
	logic signed [DW-1:0] d_sel, s_sel;
	logic [DW-1:0]        d_mag, s_mag;
	logic                 zero_z;
	logic [MW-1:0]        a_mag, b_mag;
	logic                 a_neg, b_neg;

	assign op     = pss_pkg::op_at(step_q);
	// drop z terms when z is off
	assign zero_z = (op.comp == 2'd2) && !use_z_q;
	assign d_sel  = zero_z ? '0 : d_q[op.comp];
	assign s_sel  = zero_z ? '0 : dir_q[op.comp];
	assign d_mag  = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);
	assign s_mag  = s_sel[DW-1] ? DW'(-s_sel) : DW'(s_sel);

	always_comb begin
		a_mag = '0;
		a_neg = 1'b0;
		case (op.a_src)
			pss_pkg::SRC_D: begin
				a_mag = MW'(d_mag);
				a_neg = d_sel[DW-1];
			end
			pss_pkg::SRC_S: begin
				a_mag = MW'(s_mag);
				a_neg = s_sel[DW-1];
			end
			pss_pkg::SRC_THR:      a_mag = MW'(thr_q);
			pss_pkg::SRC_DIFFD_LO: a_mag = diffd_q[MW-1:0];
			pss_pkg::SRC_DIFFD_HI: a_mag = diffd_q[SW-1:MW];
			pss_pkg::SRC_SP_LO:    a_mag = sp_q[MW-1:0];
			pss_pkg::SRC_SP_HI:    a_mag = sp_q[SW-1:MW];
			pss_pkg::SRC_THR2_LO:  a_mag = thr2_q[MW-1:0];
			pss_pkg::SRC_THR2_HI:  a_mag = thr2_q[SW-1:MW];
			default: ;
		endcase
	end

	always_comb begin
		b_mag = '0;
		b_neg = 1'b0;
		case (op.b_src)
			pss_pkg::SRC_D: begin
				b_mag = MW'(d_mag);
				b_neg = d_sel[DW-1];
			end
			pss_pkg::SRC_S: begin
				b_mag = MW'(s_mag);
				b_neg = s_sel[DW-1];
			end
			pss_pkg::SRC_THR:     b_mag = MW'(thr_q);
			pss_pkg::SRC_SUBD_LO: b_mag = subd_q[MW-1:0];
			pss_pkg::SRC_SUBD_HI: b_mag = subd_q[SW-1:MW];
			pss_pkg::SRC_SP_LO:   b_mag = sp_q[MW-1:0];
			pss_pkg::SRC_SP_HI:   b_mag = sp_q[SW-1:MW];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		prod_s1  <= a_mag * b_mag;
		dst_s1   <= op.dst;
		shift_s1 <= op.shift;
		sub_s1   <= op.neg ^ a_neg ^ b_neg;
	end

	// ---------------------------------------------------------------
	// Shared accumulate adder.
	// ---------------------------------------------------------------
	logic signed [AW-1:0] base, addend, prod_ext, sum;
	logic                 sub_eff;

	assign prod_ext = AW'(prod_s1);

	always_comb begin
		case (shift_s1)
			2'd1:    addend = prod_ext << MW;
			2'd2:    addend = prod_ext << (2 * MW);
			default: addend = prod_ext;
		endcase
		sub_eff = sub_s1;
		case (dst_s1)
			pss_pkg::DST_DIFFD: base = AW'(diffd_q);
			pss_pkg::DST_SUBD:  base = AW'(subd_q);
			pss_pkg::DST_DOT:   base = AW'(dot_q);
			pss_pkg::DST_THR2:  base = AW'(thr2_q);
			pss_pkg::DST_BIG:   base = big_q;
			pss_pkg::DST_SP: begin
				// magnitude of the dot product
				base    = '0;
				addend  = AW'(dot_q);
				sub_eff = dot_q[OW-1];
			end
			default: base = '0;
		endcase
	end

	assign sum = sub_eff ? (base - addend) : (base + addend);

	always_ff @(posedge clk) begin
		if (accept) begin
			diffd_q <= '0;
			subd_q  <= '0;
			dot_q   <= '0;
			thr2_q  <= '0;
			sp_q    <= '0;
			big_q   <= '0;
		end else if (vld_s1) begin
			case (dst_s1)
				pss_pkg::DST_DIFFD: diffd_q <= sum[SW-1:0];
				pss_pkg::DST_SUBD:  subd_q  <= sum[SW-1:0];
				pss_pkg::DST_DOT:   dot_q   <= sum[OW-1:0];
				pss_pkg::DST_THR2:  thr2_q  <= sum[SW-1:0];
				pss_pkg::DST_SP:    sp_q    <= sum[SW-1:0];
				pss_pkg::DST_BIG:   big_q   <= sum;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Kept register: hold while stalled, load only when free.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!kept_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.kept_x   <= pc_q[0];
			out_q.kept_y   <= pc_q[1];
			out_q.kept_z   <= pc_q[2];
			out_q.line_end <= last_q;
		end
	end

	assign kept_valid = out_valid_q;
	assign kept       = out_q;

endmodule

// ===== rtl/pss_checker.sv =====
module pss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               vertex_valid,
	input logic               vertex_stall,
	input logic               kept_valid,
	input logic               kept_stall,
	input pss_pkg::out_item_t kept,
	input logic               cfg_ready
);

	// a transferred vertex always goes at least through the emit state
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_stall |=> vertex_stall)
		else $error("vertex channel free right after a transfer");

	// no register writes while a vertex is in work
	a_cfg_blocked_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_stall |-> !cfg_ready)
		else $error("configuration ready while a vertex is in work");

	// a new kept vertex only comes out of a busy cycle
	a_kept_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(kept_valid) |-> $past(vertex_stall))
		else $error("kept vertex appeared without a vertex in work");

	a_kept_hold: assert property (@(posedge clk) disable iff (!arst_n)
		kept_valid && kept_stall |=> kept_valid && $stable(kept))
		else $error("stalled kept vertex changed");

endmodule

bind polyline_strip_simplifier pss_checker u_pss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.vertex_valid (vertex_valid),
	.vertex_stall (vertex_stall),
	.kept_valid   (kept_valid),
	.kept_stall   (kept_stall),
	.kept         (kept),
	.cfg_ready    (cfg_ready)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int TAIL_CYCLES = 40;      // covers the middle-vertex test
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;     // long receiver hold-off
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 48;
	localparam int PRESSURE_PHASE = 2;

	typedef enum int {
		SHAPE_WILD,
		SHAPE_NEAR,
		SHAPE_STILL
	} shape_t;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           vertex_valid = 1'b0;
	logic                           vertex_stall;
	pss_pkg::in_item_t              vertex = '0;
	logic                           kept_valid;
	logic                           kept_stall = 1'b0;
	pss_pkg::out_item_t             kept;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	polyline_strip_simplifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.vertex      (vertex),
		.kept_valid  (kept_valid),
		.kept_stall  (kept_stall),
		.kept        (kept),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// Vertices waiting to be offered, and kept vertices that must still come out.
	pss_pkg::in_item_t  vtx_pending[$];
	pss_pkg::out_item_t kept_expected[$];

	// Mirror of the block: segment, previous vertex, place in the line, registers.
	longint        anchor_pt[3];
	longint        seg_dir[3];
	longint        prev_pt[3];
	pss_pkg::pos_t line_pos;
	logic [23:0]   thr_cfg;
	logic          use_z_cfg;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_token = 0;
	int hold_served = 0;
	int hold_left = 0;
	bit vtx_sent = 1'b0;

	int mismatches = 0;
	int cycle_count = 0;
	int vertices_taken = 0;
	int lines_taken = 0;
	int kept_checked = 0;
	int regs_written = 0;

	pss_pkg::out_item_t next_kept;
	pss_pkg::out_item_t oldest_kept;

	// Exact strip test: |A-p|^2 |D|^2 > ((A-p).D)^2 + thr^2 |D|^2.
	// All terms stay below 2^102, so 128 bits hold them without loss.
	function automatic bit strip_exceeded(input longint pt[3]);
		longint       d;
		longint       s;
		longint       dot;
		logic [127:0] dd;
		logic [127:0] ss;
		logic [127:0] sp;
		logic [127:0] lhs;
		logic [127:0] rhs;
		int           dims;
		dims = use_z_cfg ? 3 : 2;
		dd = '0;
		ss = '0;
		dot = 0;
		for (int k = 0; k < dims; k++) begin
			d = anchor_pt[k] - pt[k];
			s = seg_dir[k];
			dd += 128'(d * d);
			ss += 128'(s * s);
			dot += d * s;
		end
		sp = 128'(dot < 0 ? -dot : dot);
		lhs = dd * ss;
		rhs = sp * sp + 128'(thr_cfg) * 128'(thr_cfg) * ss;
		return lhs > rhs;
	endfunction

	// Advance the mirror by one vertex; return 1 when the vertex is kept.
	function automatic bit predict_kept(input pss_pkg::in_item_t v,
			output pss_pkg::out_item_t res);
		longint pt[3];
		bit     emit;
		bit     fin;
		pt[0] = longint'($signed(v.x_coord));
		pt[1] = longint'($signed(v.y_coord));
		pt[2] = longint'($signed(v.z_coord));
		emit = 1'b0;
		fin = 1'b0;
		case (line_pos)
			pss_pkg::POS_START: begin
				emit = 1'b1;
				fin = v.last_point;
				anchor_pt = pt;
				prev_pt = pt;
				line_pos = v.last_point ? pss_pkg::POS_START : pss_pkg::POS_SECOND;
			end
			pss_pkg::POS_SECOND: begin
				for (int k = 0; k < 3; k++)
					seg_dir[k] = pt[k] - anchor_pt[k];
				prev_pt = pt;
				if (v.last_point) begin
					emit = 1'b1;
					fin = 1'b1;
					line_pos = pss_pkg::POS_START;
				end else begin
					line_pos = pss_pkg::POS_MIDDLE;
				end
			end
			default: begin
				if (v.last_point) begin
					emit = 1'b1;
					fin = 1'b1;
					line_pos = pss_pkg::POS_START;
				end else begin
					// a kept middle vertex makes (previous, itself) the new segment
					if (strip_exceeded(pt)) begin
						emit = 1'b1;
						anchor_pt = prev_pt;
						for (int k = 0; k < 3; k++)
							seg_dir[k] = pt[k] - prev_pt[k];
					end
					line_pos = pss_pkg::POS_MIDDLE;
				end
				prev_pt = pt;
			end
		endcase
		res.kept_x = v.x_coord;
		res.kept_y = v.y_coord;
		res.kept_z = v.z_coord;
		res.line_end = fin;
		return emit;
	endfunction

	task automatic report_mismatch(input string what, input pss_pkg::out_item_t got,
			input pss_pkg::out_item_t want);
		mismatches++;
		$display("ERROR @%0t %s: got (%0d,%0d,%0d) end=%0b, want (%0d,%0d,%0d) end=%0b",
			$time, what, got.kept_x, got.kept_y, got.kept_z, got.line_end,
			want.kept_x, want.kept_y, want.kept_z, want.line_end);
	endtask

	// Vertex transfer: predict at the edge that takes the item, then drop it.
	always @(posedge clk) begin
		if (arst_n && vertex_valid && !vertex_stall) begin
			if (predict_kept(vertex, next_kept))
				kept_expected.push_back(next_kept);
			void'(vtx_pending.pop_front());
			vertices_taken++;
			if (vertex.last_point)
				lines_taken++;
			vtx_sent = 1'b1;
		end
	end

	// Driver: hold an offered vertex until it transfers, otherwise maybe idle.
	always @(negedge clk) begin
		if (!(vertex_valid && !vtx_sent)) begin
			if (vtx_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				vertex_valid <= 1'b1;
				vertex <= vtx_pending[0];
			end else begin
				vertex_valid <= 1'b0;
			end
		end
		vtx_sent = 1'b0;
	end

	// Receiver: random stall, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_token != hold_served) begin
			hold_served = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			kept_stall <= 1'b1;
		end else begin
			kept_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: compare each kept transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && kept_valid && !kept_stall) begin
			if (kept_expected.size() == 0) begin
				report_mismatch("unexpected kept vertex", kept, '0);
			end else begin
				oldest_kept = kept_expected.pop_front();
				if (kept.kept_x !== oldest_kept.kept_x || kept.kept_y !== oldest_kept.kept_y
						|| kept.kept_z !== oldest_kept.kept_z
						|| kept.line_end !== oldest_kept.line_end)
					report_mismatch("kept vertex differs", kept, oldest_kept);
				kept_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d kept vertices outstanding",
				cycle_count, kept_expected.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Register write; mirror the value at the edge that takes it.
	task automatic write_reg(input logic [pss_pkg::CFG_IDX_W-1:0] idx,
			input logic [pss_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pss_pkg::CFG_THRESHOLD: thr_cfg = data;
			pss_pkg::CFG_USE_Z:     use_z_cfg = data[0];
			default: ;
		endcase
		regs_written++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every vertex is sent and every kept vertex is out, then let a middle
	// vertex that keeps nothing finish its test.
	task automatic wait_drained();
		while (vtx_pending.size() != 0 || kept_expected.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				send_idle_pct = 65;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 65;
			end
			IDLE_BOTH: begin
				send_idle_pct = 35;
				stall_pct = 35;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	task automatic push_vertex(input int x, input int y, input int z, input bit fin);
		pss_pkg::in_item_t it;
		it.x_coord = x[pss_pkg::COORD_BITS-1:0];
		it.y_coord = y[pss_pkg::COORD_BITS-1:0];
		it.z_coord = z[pss_pkg::COORD_BITS-1:0];
		it.last_point = fin;
		vtx_pending.push_back(it);
	endtask

	function automatic int rand_span(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// One polyline of n vertices. Near lines wander around a straight path by
	// about twice the threshold, so the strip test goes both ways.
	task automatic queue_line(input shape_t shape, input int n);
		int bx;
		int by;
		int bz;
		int dx;
		int dy;
		int dz;
		int noise;
		bit fin;
		bx = rand_span(1 << 22);
		by = rand_span(1 << 22);
		bz = rand_span(1 << 22);
		dx = rand_span(4096);
		dy = rand_span(4096);
		dz = rand_span(4096);
		if (thr_cfg == 0)
			noise = 4;
		else if (thr_cfg > (1 << 20))
			noise = 1 << 20;
		else
			noise = 2 * int'(thr_cfg);
		for (int i = 0; i < n; i++) begin
			fin = (i == n - 1);
			case (shape)
				SHAPE_WILD:
					push_vertex($urandom, $urandom, $urandom, fin);
				SHAPE_NEAR:
					push_vertex(bx + i * dx + rand_span(noise), by + i * dy + rand_span(noise),
						bz + i * dz + rand_span(noise), fin);
				default: begin
					// repeated start point: zero-length segment
					if (i < 2)
						push_vertex(bx, by, bz, fin);
					else
						push_vertex($urandom, $urandom, $urandom, fin);
				end
			endcase
		end
	endtask

	task automatic run_random(input int budget);
		int queued;
		int n;
		int pick;
		queued = 0;
		while (queued < budget) begin
			pick = $urandom_range(99);
			n = ($urandom_range(9) == 0) ? 1 : int'($urandom_range(12, 2));
			if (pick < 60)
				queue_line(SHAPE_NEAR, n);
			else if (pick < 85)
				queue_line(SHAPE_WILD, n);
			else
				queue_line(SHAPE_STILL, n);
			queued += n;
		end
	endtask

	initial begin
		logic [23:0] thr_plan [RAND_PHASES];
		logic [23:0] thr;
		thr_plan = '{24'hFFFFFF, 24'd1000, 24'd300, 24'd0, 24'd1, 24'd5000, 24'd60, 24'd0};
		anchor_pt = '{0, 0, 0};
		seg_dir = '{0, 0, 0};
		prev_pt = '{0, 0, 0};
		line_pos = pss_pkg::POS_START;
		thr_cfg = '0;
		use_z_cfg = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(pss_pkg::CFG_THRESHOLD, 24'd0);
		write_reg(pss_pkg::CFG_USE_Z, 24'd0);
		set_idle(IDLE_NONE);

		// single vertex line at the field extremes
		push_vertex(8388607, -8388608, 8388607, 1'b1);
		// two vertex line
		push_vertex(-8388608, 8388607, -1, 1'b0);
		push_vertex(8388607, -8388608, 0, 1'b1);
		// zero-length segment: no middle vertex passes, however far
		push_vertex(100, 200, 300, 1'b0);
		push_vertex(100, 200, 300, 1'b0);
		push_vertex(-5000, 7000, 9, 1'b0);
		push_vertex(8388607, 8388607, 8388607, 1'b0);
		push_vertex(1, 2, 3, 1'b1);
		// on the line is not outside a zero-width strip; just off it is
		push_vertex(0, 0, 0, 1'b0);
		push_vertex(10, 10, 0, 1'b0);
		push_vertex(20, 20, 0, 1'b0);
		push_vertex(30, 31, 0, 1'b0);
		push_vertex(40, 41, 5, 1'b0);
		push_vertex(-8388608, -8388608, -8388608, 1'b1);
		// z offset ignored, then z switched on within the same line
		push_vertex(0, 0, 0, 1'b0);
		push_vertex(100, 0, 0, 1'b0);
		push_vertex(200, 0, 50, 1'b0);
		wait_drained();
		write_reg(pss_pkg::CFG_USE_Z, 24'd1);
		push_vertex(300, 0, -4000, 1'b0);
		push_vertex(400, 0, 0, 1'b1);
		wait_drained();

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			thr = (phase == 5) ? 24'($urandom) : thr_plan[phase];
			write_reg(pss_pkg::CFG_THRESHOLD, thr);
			write_reg(pss_pkg::CFG_USE_Z, 24'(phase % 2));
			set_idle(idle_mode_t'(phase % 4));
			run_random(PHASE_ITEMS);
			// hold the receiver off while the sender keeps offering: fill the block
			if (phase == PRESSURE_PHASE)
				hold_token++;
			wait_drained();
		end

		$display("Checked %0d kept vertices from %0d vertices in %0d polylines",
			kept_checked, vertices_taken, lines_taken);
		$display("Ran %0d register writes: threshold 0 to full scale, z on and off, %0s",
			regs_written, "four idle mixes and a long receiver hold-off");
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pss_pkg.sv
rtl/polyline_strip_simplifier.sv
rtl/pss_checker.sv
sim/testbench.sv
